>>> hw/rtl/pbp_pkg.sv
// pbp_pkg: shared types and constants for the primitive batch planner.
// Used by every module under hw/rtl; depends on nothing.
package pbp_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_BS_POINTS     = 3'd0,
        REG_BS_LINE_LIST  = 3'd1,
        REG_BS_LINE_STRIP = 3'd2,
        REG_BS_TRI_LIST   = 3'd3,
        REG_BS_TRI_STRIP  = 3'd4,
        REG_ATTR_COUNT    = 3'd5,
        REG_ATTR_FORMATS  = 3'd6
    } reg_index_t;

    // Primitive type codes
    typedef enum logic [2:0] {
        PRIM_POINTS     = 3'd0,
        PRIM_LINE_LIST  = 3'd1,
        PRIM_LINE_STRIP = 3'd2,
        PRIM_TRI_LIST   = 3'd3,
        PRIM_TRI_STRIP  = 3'd4
    } prim_t;

    localparam int NumPrims = 5;

    // Vertices per primitive and batch overlap, by type
    localparam logic [1:0] PRIM_VERTS   [NumPrims] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3};
    localparam logic [1:0] PRIM_OVERLAP [NumPrims] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2};

    // Element bytes by size code (32, 16, 8, 16 bits)
    localparam logic [2:0] ELEM_BYTES [4] = '{3'd4, 3'd2, 3'd1, 3'd2};

    // Quadword count width before saturation
    localparam int QwW = 12;
    localparam logic [8:0] QW_MAX = 9'd511;

    // Live configuration
    typedef struct packed {
        logic [NumPrims-1:0][7:0] batch_size;
        logic [2:0]               attr_count;
        logic [15:0]              attr_formats;
    } cfg_t;

    // Classified request, front to back
    typedef struct packed {
        logic        nothing;
        logic        is_list;
        logic [1:0]  psz;
        logic [1:0]  rep;
        logic [15:0] prims;
        logic [7:0]  per;
        logic [7:0]  full;
        logic [7:0]  adv;
    } job_t;

endpackage

>>> hw/rtl/pbp_front.sv
// pbp_front: classifies a draw request into a batching job.
// Depends on pbp_pkg. Pure logic; the queue behind it registers the job.
module pbp_front (
    input  logic [2:0]     prim_type,
    input  logic [15:0]    vertex_count,
    input  pbp_pkg::cfg_t  cfg,
    output pbp_pkg::job_t  job
);

    logic        known;
    logic [1:0]  psz;
    logic [1:0]  rep;
    logic [7:0]  bs;
    logic [32:0] vc_x3;
    logic [16:0] bs_x3;
    logic [15:0] prims;
    logic [7:0]  per;
    logic [7:0]  full;
    logic        is_list;

    // Table lookup per type
    always_comb begin
        known = 1'b1;
        psz   = '0;
        rep   = '0;
        bs    = '0;
        unique case (prim_type)
            pbp_pkg::PRIM_POINTS,
            pbp_pkg::PRIM_LINE_LIST,
            pbp_pkg::PRIM_LINE_STRIP,
            pbp_pkg::PRIM_TRI_LIST,
            pbp_pkg::PRIM_TRI_STRIP: begin
                psz = pbp_pkg::PRIM_VERTS[prim_type];
                rep = pbp_pkg::PRIM_OVERLAP[prim_type];
                bs  = cfg.batch_size[prim_type];
            end
            default: known = 1'b0;
        endcase
    end

    assign is_list = prim_type[0];

    // Divide by three with reciprocal multiply (exact over these ranges)
    assign vc_x3 = 33'(vertex_count) * 33'd43691;
    assign bs_x3 = 17'(bs) * 17'd171;

    // Primitive count, primitives per batch, full batch size
    always_comb begin
        if (is_list) begin
            if (psz == 2'd2) begin
                prims = vertex_count >> 1;
                per   = bs >> 1;
                full  = {per[6:0], 1'b0};
            end else begin
                prims = 16'(vc_x3 >> 17);
                per   = 8'(bs_x3 >> 9);
                full  = 8'(10'(per) * 10'd3);
            end
        end else begin
            prims = (vertex_count > 16'(rep)) ? vertex_count - 16'(rep) : '0;
            per   = bs - 8'(rep);
            full  = bs;
        end
    end

    always_comb begin
        job.nothing = !known || (bs < 8'(psz)) || (prims == '0) || (per == '0);
        job.is_list = is_list;
        job.psz     = psz;
        job.rep     = rep;
        job.prims   = prims;
        job.per     = per;
        job.full    = full;
        job.adv     = is_list ? full : per;
    end

endmodule

>>> hw/rtl/pbp_queue.sv
// pbp_queue: two-entry job queue between front and back.
// Depends on pbp_pkg.
module pbp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pbp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pbp_pkg::job_t head_job
);

    pbp_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/pbp_div.sv
// pbp_div: pipelined 16-by-8 restoring divider, four quotient bits per stage.
// Depends on pbp_pkg; carries the job alongside the operands.
module pbp_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  pbp_pkg::job_t in_job,
    output logic          out_valid,
    output pbp_pkg::job_t out_job,
    output logic [15:0]   out_quo,
    output logic [7:0]    out_rem
);

    localparam int Stages = 4;
    localparam int BitsPerStage = 16 / Stages;

    logic [Stages-1:0] valid_reg;
    pbp_pkg::job_t     job_reg [Stages];
    logic [7:0]        rem_reg [Stages];
    logic [15:0]       dq_reg  [Stages];

    // Several restoring steps: remainder in rem, dividend bits shift into quotient
    function automatic logic [23:0] div_steps(input logic [7:0] rem, input logic [15:0] dq,
                                              input logic [7:0] dvs);
        logic [8:0]  t;
        logic [7:0]  r;
        logic [15:0] d;
        r = rem;
        d = dq;
        for (int i = 0; i < BitsPerStage; i++) begin
            t = {r, d[15]};
            if (t >= 9'(dvs)) begin
                r = 8'(t - 9'(dvs));
                d = {d[14:0], 1'b1};
            end else begin
                r = t[7:0];
                d = {d[14:0], 1'b0};
            end
        end
        return {r, d};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[Stages-2:0], in_valid};
        end
    end

    // Stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            job_reg[0]                <= in_job;
            {rem_reg[0], dq_reg[0]}   <= div_steps(8'd0, in_job.prims, in_job.per);
            for (int s = 1; s < Stages; s++) begin
                job_reg[s]              <= job_reg[s-1];
                {rem_reg[s], dq_reg[s]} <= div_steps(rem_reg[s-1], dq_reg[s-1],
                                                     job_reg[s-1].per);
            end
        end
    end

    assign out_valid = valid_reg[Stages-1];
    assign out_job   = job_reg[Stages-1];
    assign out_quo   = dq_reg[Stages-1];
    assign out_rem   = rem_reg[Stages-1];

endmodule

>>> hw/rtl/pbp_back.sv
// pbp_back: divider, batch sizing, packet lengths and the result register.
// Depends on pbp_pkg and pbp_div.
module pbp_back #(
    parameter int MaxAttr = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pbp_pkg::cfg_t cfg,
    input  logic          job_valid,
    input  pbp_pkg::job_t job,
    output logic          job_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_nothing_to_draw,
    output logic [15:0]   m_batch_count,
    output logic [7:0]    m_full_batch_vertices,
    output logic [7:0]    m_last_batch_vertices,
    output logic [7:0]    m_vertex_advance,
    output logic [8:0]    m_full_batch_quadwords,
    output logic [8:0]    m_last_batch_quadwords,
    output logic [31:0]   m_list_bytes
);

    logic          en;
    logic          dv_valid;
    pbp_pkg::job_t dv_job;
    logic [15:0]   dv_quo;
    logic [7:0]    dv_rem;

    logic [7:0]    last_prims;
    logic [7:0]    last_verts;

    logic                   sz_valid_reg;
    logic                   sz_nothing_reg;
    logic [15:0]            sz_n_reg;
    logic [7:0]             sz_full_reg;
    logic [7:0]             sz_last_reg;
    logic [7:0]             sz_adv_reg;
    logic [pbp_pkg::QwW-1:0] sz_fqw_reg;
    logic [pbp_pkg::QwW-1:0] sz_lqw_reg;

    logic          m_valid_reg;
    logic [31:0]   bytes_next;

    // Packet length in quadwords for v vertices
    function automatic logic [pbp_pkg::QwW-1:0] qw_of(input logic [7:0] v,
                                                      input logic [2:0] cnt,
                                                      input logic [15:0] fmt);
        logic [15:0] size;
        logic [3:0]  nib;
        logic [4:0]  cb;
        logic [12:0] data;
        size = 16'd28;
        for (int i = 0; i < MaxAttr; i++) begin
            nib  = 4'(32'(fmt) >> (4 * i));
            cb   = 5'((3'(nib[3:2]) + 3'd1) * pbp_pkg::ELEM_BYTES[nib[1:0]]);
            data = 13'(cb) * 13'(v);
            if (32'(i) < 32'(cnt)) begin
                size = size + 16'd4 + 16'((data + 13'd3) & ~13'd3);
            end
        end
        return pbp_pkg::QwW'((size + 16'd15) >> 4);
    endfunction

    // Whole back pipeline moves when the result register can take a transaction
    assign en      = !m_valid_reg || m_ready;
    assign job_pop = en && job_valid;
    assign m_valid = m_valid_reg;

    pbp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (job_valid),
        .in_job    (job),
        .out_valid (dv_valid),
        .out_job   (dv_job),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem)
    );

    // Last batch from the remainder
    assign last_prims = (dv_rem == '0) ? dv_job.per : dv_rem;
    assign last_verts = dv_job.is_list ? 8'(10'(last_prims) * 10'(dv_job.psz))
                                       : last_prims + 8'(dv_job.rep);

    // Sizing stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sz_valid_reg <= 1'b0;
        end else if (en) begin
            sz_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sz_nothing_reg <= dv_job.nothing;
            sz_n_reg       <= dv_quo + 16'(dv_rem != '0);
            sz_full_reg    <= dv_job.full;
            sz_last_reg    <= last_verts;
            sz_adv_reg     <= dv_job.adv;
            sz_fqw_reg     <= qw_of(dv_job.full, cfg.attr_count, cfg.attr_formats);
            sz_lqw_reg     <= qw_of(last_verts, cfg.attr_count, cfg.attr_formats);
        end
    end

    // Total list size
    assign bytes_next = 32'((40'(sz_fqw_reg) * 40'(sz_n_reg - 16'd1) + 40'(sz_lqw_reg)) << 4);

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sz_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_nothing_to_draw <= sz_nothing_reg;
            if (sz_nothing_reg) begin
                m_batch_count          <= '0;
                m_full_batch_vertices  <= '0;
                m_last_batch_vertices  <= '0;
                m_vertex_advance       <= '0;
                m_full_batch_quadwords <= '0;
                m_last_batch_quadwords <= '0;
                m_list_bytes           <= '0;
            end else begin
                m_batch_count          <= sz_n_reg;
                m_full_batch_vertices  <= sz_full_reg;
                m_last_batch_vertices  <= sz_last_reg;
                m_vertex_advance       <= sz_adv_reg;
                m_full_batch_quadwords <= (sz_fqw_reg > pbp_pkg::QwW'(pbp_pkg::QW_MAX))
                                          ? pbp_pkg::QW_MAX : sz_fqw_reg[8:0];
                m_last_batch_quadwords <= (sz_lqw_reg > pbp_pkg::QwW'(pbp_pkg::QW_MAX))
                                          ? pbp_pkg::QW_MAX : sz_lqw_reg[8:0];
                m_list_bytes           <= bytes_next;
            end
        end
    end

endmodule

>>> hw/rtl/primitive_batch_planner_unit.sv
// primitive_batch_planner_unit: top level of the draw batch planner.
// Depends on pbp_pkg, pbp_front, pbp_queue, pbp_back (with pbp_div).

// Plans the split of a draw request into vertex batches and gives packet
// lengths and total list bytes. One request is accepted per cycle when the
// two-entry job queue has room. A request passes in order through the
// queue entry, which is written at its accepting edge, the four divider
// stages, the sizing stage and the result register. The sustained rate of
// one result per cycle, while m_ready does not stall the output, comes from
// pipelining the batch-count divider into four stages. Configuration writes
// take effect at once; the user must make them only while no request is in
// flight, as the block itself does not enforce this.
module primitive_batch_planner_unit #(
    parameter int MAX_ATTRIBUTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_prim_type,
    input  logic [15:0] s_vertex_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_nothing_to_draw,
    output logic [15:0] m_batch_count,
    output logic [7:0]  m_full_batch_vertices,
    output logic [7:0]  m_last_batch_vertices,
    output logic [7:0]  m_vertex_advance,
    output logic [8:0]  m_full_batch_quadwords,
    output logic [8:0]  m_last_batch_quadwords,
    output logic [31:0] m_list_bytes
);

    pbp_pkg::cfg_t cfg_reg;
    pbp_pkg::job_t front_job;
    pbp_pkg::job_t head_job;
    logic          q_full;
    logic          head_valid;
    logic          job_pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pbp_pkg::REG_BS_POINTS,
                pbp_pkg::REG_BS_LINE_LIST,
                pbp_pkg::REG_BS_LINE_STRIP,
                pbp_pkg::REG_BS_TRI_LIST,
                pbp_pkg::REG_BS_TRI_STRIP: cfg_reg.batch_size[cfg_index] <= cfg_wdata[7:0];
                pbp_pkg::REG_ATTR_COUNT:   cfg_reg.attr_count   <= cfg_wdata[2:0];
                pbp_pkg::REG_ATTR_FORMATS: cfg_reg.attr_formats <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;

    pbp_front u_front (
        .prim_type    (s_prim_type),
        .vertex_count (s_vertex_count),
        .cfg          (cfg_reg),
        .job          (front_job)
    );

    pbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_job   (front_job),
        .full       (q_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    pbp_back #(
        .MaxAttr (MAX_ATTRIBUTES)
    ) u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg                    (cfg_reg),
        .job_valid              (head_valid),
        .job                    (head_job),
        .job_pop                (job_pop),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_nothing_to_draw      (m_nothing_to_draw),
        .m_batch_count          (m_batch_count),
        .m_full_batch_vertices  (m_full_batch_vertices),
        .m_last_batch_vertices  (m_last_batch_vertices),
        .m_vertex_advance       (m_vertex_advance),
        .m_full_batch_quadwords (m_full_batch_quadwords),
        .m_last_batch_quadwords (m_last_batch_quadwords),
        .m_list_bytes           (m_list_bytes)
    );

endmodule
